@@ rtl/cms_pkg.sv @@
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, constants and helper functions of the count-min sketch core.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int unsigned WIDTH_REG_W = 11;
  localparam int unsigned ROWS_REG_W  = 3;
  localparam int unsigned CFG_ADDR_W  = 2;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd1024;
  localparam logic [ROWS_REG_W-1:0]  ROWS_RESET  = 3'd4;

  localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
  // two golden-ratio increments per chain step, wrapped to 64 bits
  localparam logic [63:0] SEED_STEP  = 64'h3c6ef372fe94f82a;
  localparam logic [63:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2     = 64'h94d049bb133111eb;
  localparam logic [63:0] FIN_C1     = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FIN_C2     = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_EST   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SEED  = 2'd0,
    CFG_WIDTH = 2'd1,
    CFG_ROWS  = 2'd2,
    CFG_RSVD  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SH_27,
    SH_30,
    SH_31,
    SH_33
  } shift_e;

  typedef enum logic [1:0] {
    MC_MIX1,
    MC_MIX2,
    MC_FIN1,
    MC_FIN2
  } mconst_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SD_LOAD,
    ST_SD_X1,
    ST_SD_M1,
    ST_SD_X2,
    ST_SD_M2,
    ST_SD_STORE,
    ST_SD_END,
    ST_FN_LOAD,
    ST_FN_X1,
    ST_FN_M1,
    ST_FN_X2,
    ST_FN_M2,
    ST_FN_X3,
    ST_MOD,
    ST_RD,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    hash_step;
    logic    restart;
    logic    seed_init;
    logic    seed_load;
    logic    seed_store;
    logic    xsh;
    shift_e  sh_sel;
    logic    mul_en;
    logic [1:0] mul_ph;
    mconst_e mc_sel;
    logic    hash_load;
    logic    mod_step;
    logic    mem_rd;
    logic    mem_upd;
    logic    est;
    logic    clr_wr;
    logic    best_init;
    logic    item_latch;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic                  seed_wr;
    logic                  out_full;
    logic [ROWS_REG_W-1:0] eff_rows;
  } dp_sts_t;

  // (h ^ b) * 1099511628211 mod 2^64; the prime is 2^40 + 0x1b3
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] g;
    g = h ^ {56'd0, b};
    return (g << 40) + (g << 8) + (g << 7) + (g << 5) + (g << 4) + (g << 1) + g;
  endfunction

  function automatic logic [63:0] xor_shift(input logic [63:0] x, input shift_e sel);
    logic [63:0] r;
    unique case (sel)
      SH_27:   r = x ^ (x >> 27);
      SH_30:   r = x ^ (x >> 30);
      SH_31:   r = x ^ (x >> 31);
      SH_33:   r = x ^ (x >> 33);
      default: r = x;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mul_const(input mconst_e sel);
    logic [63:0] c;
    unique case (sel)
      MC_MIX1: c = MIX_C1;
      MC_MIX2: c = MIX_C2;
      MC_FIN1: c = FIN_C1;
      MC_FIN2: c = FIN_C2;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/count_min_sketch_core.sv @@
// Sequence: a key byte that is not last only steps the row hashes; a last byte runs, per row
//   in use, load, xor-shift, multiply, xor-shift, multiply, xor-shift, bit-serial modulo, read
//   and update; an estimate then sits in the result register until taken.
// Throughput: one item at a time, set by the shared 32x32 multiplier and the modulo loop.
// Reset: a sweep over all MAX_ROWS*TABLE_WIDTH words zeroes the counters (a clear transaction
//   repeats it), then the row seeds are derived (a seed write repeats this); no input meanwhile.
// ----------------------------------------------------------------------------
// count_min_sketch_core
// Count-min sketch with byte-serial keys, seeded FNV-1a rows and a murmur-style
// finalizer; counters live in one RAM of MAX_ROWS x TABLE_WIDTH words.
// ----------------------------------------------------------------------------
module count_min_sketch_core #(
  parameter int unsigned MAX_ROWS    = 4,
  parameter int unsigned TABLE_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // [7:0] key_byte, [71:8] amount
  input  logic [2:0]  s_axis_tuser_i,   // [1:0] cmd, [2] byte_present
  input  logic        s_axis_tlast_i,   // last_byte
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // [63:0] estimate_count
);

  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ADDR_W = $clog2(MAX_ROWS * TABLE_WIDTH);

  cms_pkg::dp_cmd_t  dp_cmd;
  cms_pkg::dp_sts_t  dp_sts;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] clr_addr;

  // Register writes are always taken; a seed write re-arms seed derivation, which waits
  // until the sequencer is idle and blocks the input stream until seeds are ready.
  assign cfg_ready_o = 1'b1;

  // Controller: walks seed chain, finalize/modulo/update per row and the clear
  // sweep; it owns the row index and the sweep address.
  cms_ctrl #(
    .MAX_ROWS    (MAX_ROWS),
    .TABLE_WIDTH (TABLE_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (s_axis_tuser_i[1:0]),
    .in_present_i (s_axis_tuser_i[2]),
    .in_last_i    (s_axis_tlast_i),
    .sts_i        (dp_sts),
    .cmd_o        (dp_cmd),
    .row_o        (row),
    .clr_addr_o   (clr_addr)
  );

  // Datapath: all hash rows step together on each byte (FNV prime is a
  // shift-add); 64-bit multiplies by the mixing constants use one 32x32 unit.
  cms_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .TABLE_WIDTH (TABLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .key_byte_i  (s_axis_tdata_i[7:0]),
    .amount_i    (s_axis_tdata_i[71:8]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .cmd_i       (dp_cmd),
    .row_i       (row),
    .clr_addr_i  (clr_addr),
    .sts_o       (dp_sts)
  );

endmodule

@@ rtl/cms_ram.sv @@
// ----------------------------------------------------------------------------
// cms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cms_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cms_ctrl.sv @@
// ----------------------------------------------------------------------------
// cms_ctrl
// Sequencer: seed derivation, key finalize per row, counter clear sweep.
// ----------------------------------------------------------------------------
module cms_ctrl #(
  parameter int unsigned MAX_ROWS    = 4,
  parameter int unsigned TABLE_WIDTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             in_cmd_i,
  input  logic                   in_present_i,
  input  logic                   in_last_i,
  input  cms_pkg::dp_sts_t       sts_i,
  output cms_pkg::dp_cmd_t       cmd_o,
  output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0]   row_o,
  output logic [$clog2(MAX_ROWS*TABLE_WIDTH)-1:0]             clr_addr_o
);

  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned RC_W   = $clog2(MAX_ROWS + 1);
  localparam int unsigned DEPTH  = MAX_ROWS * TABLE_WIDTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  cms_pkg::state_e   state_q, state_d;
  logic [RC_W-1:0]   r_q, r_d;
  logic [1:0]        ph_q, ph_d;
  logic [5:0]        bit_q, bit_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              pend_q, pend_d;
  logic              est_q, est_d;
  logic              last_row;
  logic              last_seed;

  assign last_row  = (32'(r_q) + 32'd1 == 32'(sts_i.eff_rows));
  assign last_seed = (32'(r_q) == MAX_ROWS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cms_pkg::ST_CLEAR;
      r_q     <= '0;
      ph_q    <= '0;
      bit_q   <= '0;
      clr_q   <= '0;
      pend_q  <= 1'b1;
      est_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      ph_q    <= ph_d;
      bit_q   <= bit_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      est_q   <= est_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    ph_d       = ph_q;
    bit_d      = bit_q;
    clr_d      = clr_q;
    est_d      = est_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.est  = est_q;

    unique case (state_q)
      cms_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        clr_d        = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = cms_pkg::ST_IDLE;
        end
      end
      cms_pkg::ST_IDLE: begin
        if (pend_q) begin
          cmd_o.seed_init = 1'b1;
          r_d             = '0;
          state_d         = cms_pkg::ST_SD_LOAD;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            unique case (in_cmd_i)
              cms_pkg::CMD_CLEAR: begin
                cmd_o.restart = 1'b1;
                clr_d         = '0;
                state_d       = cms_pkg::ST_CLEAR;
              end
              cms_pkg::CMD_ADD, cms_pkg::CMD_EST: begin
                cmd_o.hash_step = in_present_i;
                if (in_last_i) begin
                  cmd_o.item_latch = 1'b1;
                  cmd_o.best_init  = 1'b1;
                  est_d            = (in_cmd_i == cms_pkg::CMD_EST);
                  r_d              = '0;
                  state_d          = (sts_i.eff_rows == '0) ? cms_pkg::ST_DONE
                                                            : cms_pkg::ST_FN_LOAD;
                end
              end
              default: ;
            endcase
          end
        end
      end
      cms_pkg::ST_SD_LOAD: begin
        cmd_o.seed_load = 1'b1;
        state_d         = cms_pkg::ST_SD_X1;
      end
      cms_pkg::ST_SD_X1: begin
        cmd_o.xsh    = 1'b1;
        cmd_o.sh_sel = cms_pkg::SH_30;
        ph_d         = '0;
        state_d      = cms_pkg::ST_SD_M1;
      end
      cms_pkg::ST_SD_M1: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_ph = ph_q;
        cmd_o.mc_sel = cms_pkg::MC_MIX1;
        ph_d         = ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          ph_d    = '0;
          state_d = cms_pkg::ST_SD_X2;
        end
      end
      cms_pkg::ST_SD_X2: begin
        cmd_o.xsh    = 1'b1;
        cmd_o.sh_sel = cms_pkg::SH_27;
        state_d      = cms_pkg::ST_SD_M2;
      end
      cms_pkg::ST_SD_M2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_ph = ph_q;
        cmd_o.mc_sel = cms_pkg::MC_MIX2;
        ph_d         = ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          ph_d    = '0;
          state_d = cms_pkg::ST_SD_STORE;
        end
      end
      cms_pkg::ST_SD_STORE: begin
        cmd_o.seed_store = 1'b1;
        if (last_seed) begin
          state_d = cms_pkg::ST_SD_END;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = cms_pkg::ST_SD_LOAD;
        end
      end
      cms_pkg::ST_SD_END: begin
        cmd_o.restart = 1'b1;
        state_d       = cms_pkg::ST_IDLE;
      end
      cms_pkg::ST_FN_LOAD: begin
        cmd_o.hash_load = 1'b1;
        state_d         = cms_pkg::ST_FN_X1;
      end
      cms_pkg::ST_FN_X1: begin
        cmd_o.xsh    = 1'b1;
        cmd_o.sh_sel = cms_pkg::SH_33;
        ph_d         = '0;
        state_d      = cms_pkg::ST_FN_M1;
      end
      cms_pkg::ST_FN_M1: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_ph = ph_q;
        cmd_o.mc_sel = cms_pkg::MC_FIN1;
        ph_d         = ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          ph_d    = '0;
          state_d = cms_pkg::ST_FN_X2;
        end
      end
      cms_pkg::ST_FN_X2: begin
        cmd_o.xsh    = 1'b1;
        cmd_o.sh_sel = cms_pkg::SH_33;
        state_d      = cms_pkg::ST_FN_M2;
      end
      cms_pkg::ST_FN_M2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_ph = ph_q;
        cmd_o.mc_sel = cms_pkg::MC_FIN2;
        ph_d         = ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          ph_d    = '0;
          state_d = cms_pkg::ST_FN_X3;
        end
      end
      cms_pkg::ST_FN_X3: begin
        cmd_o.xsh    = 1'b1;
        cmd_o.sh_sel = cms_pkg::SH_33;
        bit_d        = '0;
        state_d      = cms_pkg::ST_MOD;
      end
      cms_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        bit_d          = bit_q + 1'b1;
        if (bit_q == 6'd63) begin
          state_d = cms_pkg::ST_RD;
        end
      end
      cms_pkg::ST_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = cms_pkg::ST_UPD;
      end
      cms_pkg::ST_UPD: begin
        cmd_o.mem_upd = 1'b1;
        if (last_row) begin
          state_d = cms_pkg::ST_DONE;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = cms_pkg::ST_FN_LOAD;
        end
      end
      cms_pkg::ST_DONE: begin
        cmd_o.restart = 1'b1;
        if (!est_q) begin
          state_d = cms_pkg::ST_IDLE;
        end else if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = cms_pkg::ST_IDLE;
        end
      end
      default: state_d = cms_pkg::ST_IDLE;
    endcase

    // a seed write landing while the chain starts re-arms the derivation
    pend_d = sts_i.seed_wr | (pend_q & ~cmd_o.seed_init);
  end

  assign row_o      = r_q[ROW_W-1:0];
  assign clr_addr_o = clr_q;

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_full)
    else $error("result register overwritten while still held");

  a_mul_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q != 2'd3)
    else $error("multiply phase out of range");

  a_mod_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cms_pkg::ST_MOD |-> 32'(r_q) < 32'(sts_i.eff_rows))
    else $error("finalize on a row outside the rows in use");

endmodule

@@ rtl/cms_dp.sv @@
// ----------------------------------------------------------------------------
// cms_dp
// Datapath: config registers, row hashes and seeds, shared 32x32 multiplier,
// bit-serial modulo, counter memory and result register.
// ----------------------------------------------------------------------------
module cms_dp #(
  parameter int unsigned MAX_ROWS    = 4,
  parameter int unsigned TABLE_WIDTH = 1024
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              cfg_valid_i,
  input  logic [cms_pkg::CFG_ADDR_W-1:0]                    cfg_addr_i,
  input  logic [63:0]                                       cfg_data_i,
  input  logic [7:0]                                        key_byte_i,
  input  logic [63:0]                                       amount_i,
  input  logic                                              out_ready_i,
  output logic                                              out_valid_o,
  output logic [63:0]                                       out_data_o,
  input  cms_pkg::dp_cmd_t                                  cmd_i,
  input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0]  row_i,
  input  logic [$clog2(MAX_ROWS*TABLE_WIDTH)-1:0]           clr_addr_i,
  output cms_pkg::dp_sts_t                                  sts_o
);

  localparam int unsigned DEPTH  = MAX_ROWS * TABLE_WIDTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned COL_W  = $clog2(TABLE_WIDTH);
  localparam int unsigned WW     = cms_pkg::WIDTH_REG_W;

  logic [63:0]                       hash_seed_q;
  logic [WW-1:0]                     width_q;
  logic [cms_pkg::ROWS_REG_W-1:0]    rows_q;
  logic [63:0]                       row_seed_q [MAX_ROWS];
  logic [63:0]                       row_hash_q [MAX_ROWS];
  logic [63:0]                       s_q, x_q, acc_q;
  logic [WW-1:0]                     rem_q;
  logic [63:0]                       amount_q, best_q, out_q;
  logic                              out_valid_q;

  logic [WW-1:0]      effw;
  logic [WW:0]        mod_t;
  logic [63:0]        mconst;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [63:0]        seed_v;
  logic [ADDR_W-1:0]  addr;
  logic [63:0]        rdata;
  logic               cfg_wr;

  assign cfg_wr = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_seed_q <= '0;
      width_q     <= cms_pkg::WIDTH_RESET;
      rows_q      <= cms_pkg::ROWS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr && cfg_addr_i == cms_pkg::CFG_SEED) begin
        hash_seed_q <= cfg_data_i;
      end
      if (cfg_wr && cfg_addr_i == cms_pkg::CFG_WIDTH) begin
        width_q <= cfg_data_i[WW-1:0];
      end
      if (cfg_wr && cfg_addr_i == cms_pkg::CFG_ROWS) begin
        rows_q <= cfg_data_i[cms_pkg::ROWS_REG_W-1:0];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // width zero acts as one, wider than the table saturates
  always_comb begin
    if (width_q == '0) begin
      effw = WW'(1);
    end else if (32'(width_q) > TABLE_WIDTH) begin
      effw = WW'(TABLE_WIDTH);
    end else begin
      effw = width_q;
    end
  end

  assign sts_o.eff_rows = (32'(rows_q) > MAX_ROWS) ? cms_pkg::ROWS_REG_W'(MAX_ROWS) : rows_q;
  assign sts_o.seed_wr  = cfg_wr && cfg_addr_i == cms_pkg::CFG_SEED;
  assign sts_o.out_full = out_valid_q & ~out_ready_i;

  // low 64 bits of x * c from three 32x32 partial products
  assign mconst = cms_pkg::mul_const(cmd_i.mc_sel);
  assign mul_a  = (cmd_i.mul_ph == 2'd2) ? x_q[63:32] : x_q[31:0];
  assign mul_b  = (cmd_i.mul_ph == 2'd1) ? mconst[63:32] : mconst[31:0];
  assign prod   = mul_a * mul_b;

  assign seed_v = cms_pkg::xor_shift(x_q, cms_pkg::SH_31);
  assign mod_t  = {rem_q, x_q[63]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_init) begin
      s_q <= hash_seed_q;
    end else if (cmd_i.seed_store) begin
      s_q <= seed_v;
    end

    if (cmd_i.seed_store) begin
      row_seed_q[row_i] <= seed_v;
    end

    for (int i = 0; i < MAX_ROWS; i++) begin
      if (cmd_i.restart) begin
        row_hash_q[i] <= cms_pkg::FNV_OFFSET ^ row_seed_q[i];
      end else if (cmd_i.hash_step) begin
        row_hash_q[i] <= cms_pkg::fnv_step(row_hash_q[i], key_byte_i);
      end
    end

    if (cmd_i.seed_load) begin
      x_q <= s_q + 64'(row_i) + cms_pkg::SEED_STEP;
    end else if (cmd_i.xsh) begin
      x_q <= cms_pkg::xor_shift(x_q, cmd_i.sh_sel);
    end else if (cmd_i.mul_en && cmd_i.mul_ph == 2'd2) begin
      x_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
    end else if (cmd_i.hash_load) begin
      x_q <= row_hash_q[row_i];
    end else if (cmd_i.mod_step) begin
      x_q <= {x_q[62:0], 1'b0};
    end

    if (cmd_i.mul_en && cmd_i.mul_ph == 2'd0) begin
      acc_q <= prod;
    end else if (cmd_i.mul_en && cmd_i.mul_ph == 2'd1) begin
      acc_q <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
    end

    if (cmd_i.hash_load) begin
      rem_q <= '0;
    end else if (cmd_i.mod_step) begin
      if (mod_t >= {1'b0, effw}) begin
        rem_q <= WW'(mod_t - {1'b0, effw});
      end else begin
        rem_q <= mod_t[WW-1:0];
      end
    end

    if (cmd_i.item_latch) begin
      amount_q <= amount_i;
    end

    if (cmd_i.best_init) begin
      best_q <= '1;
    end else if (cmd_i.mem_upd && cmd_i.est && rdata < best_q) begin
      best_q <= rdata;
    end

    if (cmd_i.out_load) begin
      out_q <= (best_q == '1) ? '0 : best_q;
    end
  end

  assign addr = ADDR_W'(32'(row_i) * TABLE_WIDTH + 32'(COL_W'(rem_q)));

  cms_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_counters (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_wr | (cmd_i.mem_upd & ~cmd_i.est)),
    .waddr_i (cmd_i.clr_wr ? clr_addr_i : addr),
    .wdata_i (cmd_i.clr_wr ? 64'd0 : rdata + amount_q),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_rd |-> rem_q < effw)
    else $error("counter index not below the width in use");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_wr && cmd_i.mem_upd))
    else $error("clear sweep and counter update collide");

endmodule
